FILE: hw/rtl/scds_pkg.sv
package scds_pkg;

    localparam int KHZ_W   = 20;
    localparam int MHZ_W   = 10;
    localparam int CFG_W   = 20;
    localparam int TGT_W   = 31;
    localparam int NUM_W   = 32;   // dividend / quotient width
    localparam int DEN_W   = 18;   // divisor width, 7 * 32768 fits
    localparam int PI_W    = 3;
    localparam int SI_W    = 4;

    localparam logic [KHZ_W-1:0] KHZ_RESET = KHZ_W'(50000);
    localparam logic [MHZ_W-1:0] MHZ_RESET = MHZ_W'(50);

    localparam logic [PI_W-1:0] BAUD_LAST_PI  = PI_W'(4);
    localparam logic [PI_W-1:0] DELAY_LAST_PI = PI_W'(3);
    localparam logic [SI_W-1:0] LAST_SI       = SI_W'(15);
    localparam int              DELAY_SHIFT0  = 4;   // scaler base 0x10

    // configuration register indexes
    typedef enum logic {
        CFG_BUS_KHZ = 1'b0,
        CFG_BUS_MHZ = 1'b1
    } t_cfg_idx;

    // request modes
    typedef enum logic {
        MODE_BAUD  = 1'b0,
        MODE_DELAY = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_CMP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic [2:0] baud_pre(input logic [PI_W-1:0] idx);
        logic [2:0] v;
        case (idx)
            3'd0:    v = 3'd1;
            3'd1:    v = 3'd2;
            3'd2:    v = 3'd3;
            3'd3:    v = 3'd5;
            default: v = 3'd7;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] baud_scl(input logic [SI_W-1:0] idx);
        logic [15:0] v;
        case (idx)
            4'd0:    v = 16'd2;
            4'd1:    v = 16'd4;
            4'd2:    v = 16'd6;
            default: v = 16'd8 << (idx - 4'd3);
        endcase
        return v;
    endfunction

    // delay prescaler times ns per us
    function automatic logic [12:0] delay_pre_ns(input logic [PI_W-1:0] idx);
        logic [12:0] v;
        case (idx)
            3'd0:    v = 13'd1000;
            3'd1:    v = 13'd3000;
            3'd2:    v = 13'd5000;
            default: v = 13'd7000;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/scds_operand.sv
module scds_operand (
    input  logic                        i_mode,
    input  logic [scds_pkg::PI_W-1:0]   i_pi,
    input  logic [scds_pkg::SI_W-1:0]   i_si,
    input  logic [scds_pkg::KHZ_W-1:0]  i_khz,
    input  logic [scds_pkg::MHZ_W-1:0]  i_mhz,
    output scds_pkg::t_div_req          o_req
);
    import scds_pkg::*;

    logic [DEN_W:0]   baud_prod;
    logic [NUM_W-1:0] delay_num;
    logic [MHZ_W-1:0] mhz_nz;
    logic [4:0]       delay_sh;

    assign baud_prod = (DEN_W+1)'(baud_pre(i_pi)) * (DEN_W+1)'(baud_scl(i_si));
    assign delay_sh  = 5'(i_si) + 5'(DELAY_SHIFT0);
    assign delay_num = NUM_W'(delay_pre_ns(i_pi)) << delay_sh;
    // zero MHz behaves as 1
    assign mhz_nz    = (i_mhz == '0) ? MHZ_W'(1) : i_mhz;

    always_comb begin
        if (i_mode == MODE_DELAY) begin
            o_req.dividend = delay_num;
            o_req.divisor  = DEN_W'(mhz_nz);
        end else begin
            o_req.dividend = NUM_W'(i_khz);
            o_req.divisor  = baud_prod[DEN_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/scds_divider.sv
module scds_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  scds_pkg::t_div_req i_req,
    output scds_pkg::t_div_rsp o_rsp
);
    import scds_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_div;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // one restoring step per cycle
    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: hw/rtl/spi_clock_divider_search.sv
// SPI clock divider search.
// Request channel (i_valid / o_ready): i_mode selects baud search (0, target
// in kHz) or delay search (1, target in ns). Result channel (o_valid /
// i_ready) returns the chosen prescaler/scaler indexes plus the register
// fields derived from them. Configuration: i_cfg_we writes i_cfg_data to
// bus_clock_khz (index 0) or bus_clock_mhz (index 1) on the same edge.
// One request at a time: o_ready is high only when no request is in flight.
// Each candidate takes one 32-step serial restoring divider pass plus launch,
// difference and compare steps. Baud search scans up to 80 candidates, delay
// search up to 64; an exact match ends the scan at the current candidate.
// The result is held in registers until taken; a stalled receiver just
// keeps o_valid high and the next request waits behind it.
// Reset (synchronous, active low) returns to idle and loads the bus clock
// registers with 50000 kHz / 50 MHz.
module spi_clock_divider_search (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [scds_pkg::CFG_W-1:0]   i_cfg_data,
    // request
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_mode,
    input  logic [scds_pkg::TGT_W-1:0]   i_target,
    // result
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [2:0]                   o_prescaler_index,
    output logic [3:0]                   o_scaler_index,
    output logic                         o_double_rate,
    output logic [1:0]                   o_prescaler_field
);
    import scds_pkg::*;

    t_state r_state, n_state;

    logic [KHZ_W-1:0] r_khz;
    logic [MHZ_W-1:0] r_mhz;

    logic             r_mode;
    logic [TGT_W-1:0] r_target;
    logic [PI_W-1:0]  r_pi;
    logic [SI_W-1:0]  r_si;
    logic [PI_W-1:0]  r_best_pi;
    logic [SI_W-1:0]  r_best_si;
    logic [NUM_W-1:0] r_best;
    logic             r_have;
    logic [NUM_W-1:0] r_diff;

    t_div_req         div_req;
    t_div_rsp         div_rsp;
    logic             div_start;

    logic             better;
    logic             exact;
    logic             last_cand;
    logic [NUM_W-1:0] tgt_ext;

    // ---------------- configuration registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_khz <= KHZ_RESET;
            r_mhz <= MHZ_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BUS_KHZ: r_khz <= i_cfg_data[KHZ_W-1:0];
                CFG_BUS_MHZ: r_mhz <= i_cfg_data[MHZ_W-1:0];
                default:     ;
            endcase
        end
    end

    // ---------------- shared datapath ----------------
    scds_operand u_operand (
        .i_mode (r_mode),
        .i_pi   (r_pi),
        .i_si   (r_si),
        .i_khz  (r_khz),
        .i_mhz  (r_mhz),
        .o_req  (div_req)
    );

    scds_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign tgt_ext   = NUM_W'(r_target);
    // first candidate always wins, then strictly smaller only
    assign better    = !r_have || (r_diff < r_best);
    assign exact     = better && (r_diff == '0);
    assign last_cand = (r_si == LAST_SI) &&
                       (r_pi == ((r_mode == MODE_DELAY) ? DELAY_LAST_PI : BAUD_LAST_PI));

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_START;
            ST_START: n_state = ST_WAIT;
            ST_WAIT:  if (div_rsp.done) n_state = ST_CMP;
            ST_CMP:   n_state = (exact || last_cand) ? ST_OUT : ST_START;
            ST_OUT:   if (i_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = (r_state == ST_IDLE);
        o_valid   = (r_state == ST_OUT);
        div_start = (r_state == ST_START);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_mode   <= i_mode;
            r_target <= i_target;
            r_pi     <= '0;
            r_si     <= '0;
            r_have   <= 1'b0;
        end
        if (r_state == ST_WAIT && div_rsp.done) begin
            r_diff <= (div_rsp.quotient >= tgt_ext) ? div_rsp.quotient - tgt_ext
                                                    : tgt_ext - div_rsp.quotient;
        end
        if (r_state == ST_CMP) begin
            if (better) begin
                r_best    <= r_diff;
                r_best_pi <= r_pi;
                r_best_si <= r_si;
                r_have    <= 1'b1;
            end
            // scaler-minor scan order
            if (r_si == LAST_SI) begin
                r_si <= '0;
                r_pi <= r_pi + PI_W'(1);
            end else begin
                r_si <= r_si + SI_W'(1);
            end
        end
    end

    // ---------------- result fields ----------------
    always_comb begin
        o_prescaler_index = r_best_pi;
        o_scaler_index    = r_best_si;
        if (r_mode == MODE_DELAY) begin
            o_double_rate     = 1'b0;
            o_prescaler_field = r_best_pi[1:0];
        end else if (r_best_pi == '0) begin
            o_double_rate     = 1'b1;
            o_prescaler_field = 2'd0;
        end else begin
            o_double_rate     = 1'b0;
            o_prescaler_field = 2'(r_best_pi - PI_W'(1));
        end
    end

endmodule

FILE: hw/rtl/scds_checker.sv
module scds_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       o_ready,
    input  logic       o_valid,
    input  logic       i_ready,
    input  logic [2:0] o_prescaler_index,
    input  logic [3:0] o_scaler_index,
    input  logic       o_double_rate,
    input  logic [1:0] o_prescaler_field
);

    // a held result keeps its indexes and prescaler field
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_prescaler_index) &&
            $stable(o_scaler_index) && $stable(o_prescaler_field))
        else $error("result changed while stalled");

    // one request in flight: no intake while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("ready while result pending");

    // an accepted request keeps the block busy for at least the next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready && !o_valid)
        else $error("block not busy after request");

    // double rate only with the first prescaler and a zero field
    a_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_double_rate |-> o_prescaler_index == 3'd0 &&
            o_prescaler_field == 2'd0)
        else $error("double rate with wrong prescaler");

    a_pre_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_prescaler_index <= 3'd4)
        else $error("prescaler index out of range");

endmodule

bind spi_clock_divider_search scds_checker u_scds_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_prescaler_index (o_prescaler_index),
    .o_scaler_index    (o_scaler_index),
    .o_double_rate     (o_double_rate),
    .o_prescaler_field (o_prescaler_field)
);

FILE: tb/tb_spi_clock_divider_search.sv
module tb_spi_clock_divider_search;

    import scds_pkg::*;

    localparam logic [TGT_W-1:0] TARGET_MAX = 31'h7FFF_FFFF;

    // The slowest request is a full baud scan. On top of that come a long receiver
    // stall and a long sender gap. This limit allows several times that before the
    // run is declared hung.
    localparam int unsigned WATCHDOG_LIMIT     = 20000;
    localparam int unsigned DRAIN_CYCLES       = 100;
    localparam int unsigned RANDOM_PHASES      = 8;
    localparam int unsigned REQUESTS_PER_PHASE = 26;

    typedef struct packed {
        logic [2:0] pre_idx;
        logic [3:0] scl_idx;
        logic       dbl;
        logic [1:0] pre_field;
    } divider_choice_t;

    typedef struct packed {
        logic             mode;
        logic [TGT_W-1:0] target;
    } divider_request_t;

    // Tracks the bus clock registers and holds the divider choice that each
    // accepted request should produce, oldest first.
    class divider_scoreboard;
        bit [19:0]       bus_khz;
        bit [9:0]        bus_mhz;
        divider_choice_t expected_choices[$];
        int unsigned     mismatches;

        function new();
            bus_khz    = 50000;
            bus_mhz    = 50;
            mismatches = 0;
        endfunction

        function int unsigned outstanding();
            return expected_choices.size();
        endfunction

        function void note_config(t_cfg_idx idx, logic [CFG_W-1:0] value);
            if (idx == CFG_BUS_KHZ) begin
                bus_khz = value[19:0];
            end else begin
                bus_mhz = value[9:0];
            end
        endfunction

        // Rate in kHz (baud) or delay in ns (delay) of one candidate pair.
        function longint unsigned candidate_value(bit delay_mode, int unsigned p,
                                                  int unsigned s);
            longint unsigned pre, scl, mhz;
            if (delay_mode) begin
                case (p)
                    0:       pre = 1;
                    1:       pre = 3;
                    2:       pre = 5;
                    default: pre = 7;
                endcase
                mhz = (bus_mhz == 0) ? 1 : bus_mhz;
                return (pre * (64'd16 << s) * 64'd1000) / mhz;
            end
            case (p)
                0:       pre = 1;
                1:       pre = 2;
                2:       pre = 3;
                3:       pre = 5;
                default: pre = 7;
            endcase
            scl = (s < 3) ? 2 * (s + 1) : (64'd8 << (s - 3));
            return longint'(bus_khz) / (pre * scl);
        endfunction

        // Scan in prescaler-major order. A strictly smaller difference wins,
        // and an exact hit ends the scan.
        function divider_choice_t search_dividers(bit delay_mode, logic [TGT_W-1:0] target);
            divider_choice_t c;
            longint unsigned best, diff, cand, tgt;
            int unsigned     last_pre, p, s;
            bit              hit;
            c        = '0;
            best     = '1;
            hit      = 1'b0;
            tgt      = target;
            last_pre = delay_mode ? 3 : 4;
            for (p = 0; p <= last_pre && !hit; p++) begin
                for (s = 0; s < 16 && !hit; s++) begin
                    cand = candidate_value(delay_mode, p, s);
                    diff = (cand >= tgt) ? cand - tgt : tgt - cand;
                    if (diff < best) begin
                        best      = diff;
                        c.pre_idx = p[2:0];
                        c.scl_idx = s[3:0];
                    end
                    if (best == 0) hit = 1'b1;
                end
            end
            if (delay_mode) begin
                c.dbl       = 1'b0;
                c.pre_field = c.pre_idx[1:0];
            end else if (c.pre_idx == 0) begin
                c.dbl       = 1'b1;
                c.pre_field = 2'd0;
            end else begin
                c.dbl       = 1'b0;
                c.pre_field = 2'(c.pre_idx - 3'd1);
            end
            return c;
        endfunction

        function void note_request(bit delay_mode, logic [TGT_W-1:0] target);
            expected_choices.push_back(search_dividers(delay_mode, target));
        endfunction

        task report(string what, logic [31:0] want, logic [31:0] got);
            $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
            mismatches++;
        endtask

        task check_result(divider_choice_t got);
            divider_choice_t want;
            if (expected_choices.size() == 0) begin
                report("result with no request waiting", 0, 32'(got));
                return;
            end
            want = expected_choices.pop_front();
            if (got.pre_idx !== want.pre_idx)
                report("prescaler_index", want.pre_idx, got.pre_idx);
            if (got.scl_idx !== want.scl_idx)
                report("scaler_index", want.scl_idx, got.scl_idx);
            if (got.dbl !== want.dbl)
                report("double_rate", want.dbl, got.dbl);
            if (got.pre_field !== want.pre_field)
                report("prescaler_field", want.pre_field, got.pre_field);
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_valid;
    logic             o_ready;
    logic             i_mode;
    logic [TGT_W-1:0] i_target;
    logic             o_valid;
    logic             i_ready;
    logic [2:0]       o_prescaler_index;
    logic [3:0]       o_scaler_index;
    logic             o_double_rate;
    logic [1:0]       o_prescaler_field;

    spi_clock_divider_search DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_mode            (i_mode),
        .i_target          (i_target),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_prescaler_index (o_prescaler_index),
        .o_scaler_index    (o_scaler_index),
        .o_double_rate     (o_double_rate),
        .o_prescaler_field (o_prescaler_field)
    );

    divider_scoreboard sb = new();
    divider_request_t  request_queue[$];
    // When set, neither side idles: back-to-back requests, receiver always ready.
    bit                steady;
    int unsigned       ready_hold;
    int unsigned       idle_cycles;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 4);
        if (r < 97) return $urandom_range(5, 20);
        return $urandom_range(50, 300);
    endfunction

    function automatic logic [TGT_W-1:0] clamp_target(longint t);
        if (t < 0) return '0;
        if (t > longint'(TARGET_MAX)) return TARGET_MAX;
        return t[TGT_W-1:0];
    endfunction

    // Random request. Four in ten land on or next to a real candidate (exact hits
    // end the scan early), two in ten halfway between two candidates (ties), and the
    // rest are log-spread or fully random targets.
    function automatic divider_request_t make_random_request();
        divider_request_t r;
        int unsigned      style, last_pre, w;
        longint           c1, c2;
        bit               is_delay;
        r.mode   = $urandom_range(0, 1);
        is_delay = (r.mode == MODE_DELAY);
        last_pre = is_delay ? 3 : 4;
        style    = $urandom_range(0, 9);
        c1 = longint'(sb.candidate_value(is_delay, $urandom_range(0, last_pre),
                                         $urandom_range(0, 15)));
        c2 = longint'(sb.candidate_value(is_delay, $urandom_range(0, last_pre),
                                         $urandom_range(0, 15)));
        if (style < 4) begin
            r.target = clamp_target(c1 + $signed($urandom_range(0, 6)) - 3);
        end else if (style < 6) begin
            r.target = clamp_target((c1 + c2) / 2);
        end else if (style < 8) begin
            w        = $urandom_range(1, TGT_W);
            r.target = TGT_W'($urandom & ((32'd1 << w) - 1));
        end else begin
            r.target = TGT_W'($urandom);
        end
        return r;
    endfunction

    function automatic logic [19:0] pick_bus_khz();
        case ($urandom_range(0, 5))
            0:       return 20'd1;
            1:       return 20'hFFFFF;
            2:       return 20'($urandom_range(1, 2000));
            3:       return 20'($urandom_range(2000, 200000));
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic logic [9:0] pick_bus_mhz();
        case ($urandom_range(0, 3))
            0:       return 10'd1;
            1:       return 10'd1023;
            2:       return 10'($urandom_range(1, 100));
            default: return 10'($urandom);
        endcase
    endfunction

    // Register writes only go in once every request has been answered, so the
    // block is idle and the scoreboard can switch settings at the same point.
    task automatic write_register(t_cfg_idx idx, logic [CFG_W-1:0] value);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.note_config(idx, value);
    endtask

    task automatic queue_request(bit mode, logic [TGT_W-1:0] target);
        request_queue.push_back('{mode, target});
    endtask

    // Sends every queued request. Valid stays up across back-to-back requests
    // and is only lowered for a gap or after the last one, so each edge sees
    // at most one update of i_valid.
    task automatic drive_requests();
        divider_request_t r;
        int unsigned      gap;
        while (request_queue.size() > 0) begin
            r   = request_queue.pop_front();
            gap = pick_gap();
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid  <= 1'b1;
            i_mode   <= r.mode;
            i_target <= r.target;
            do @(posedge i_clk); while (o_ready !== 1'b1);
            sb.note_request(r.mode == MODE_DELAY, r.target);
        end
        i_valid <= 1'b0;
    endtask

    // Result side: check on each accepted result, then pick the next ready
    // level. Ready and stall stretches of random lengths follow in random order.
    initial begin
        divider_choice_t got;
        i_ready    <= 1'b0;
        ready_hold = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_ready === 1'b1) begin
                got.pre_idx   = o_prescaler_index;
                got.scl_idx   = o_scaler_index;
                got.dbl       = o_double_rate;
                got.pre_field = o_prescaler_field;
                sb.check_result(got);
            end
            if (ready_hold > 0) begin
                ready_hold--;
            end else begin
                ready_hold = pick_gap();
                if (ready_hold == 0) begin
                    i_ready    <= 1'b1;
                    ready_hold = $urandom_range(0, 30);
                end else begin
                    i_ready    <= 1'b0;
                    ready_hold = ready_hold - 1;
                end
            end
        end
    end

    // Hang detection: any stretch with no request or result handshake that
    // runs past the limit ends the run.
    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int unsigned phase, n;
        idle_cycles = 0;
        steady      = 1'b0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_BUS_KHZ;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_mode     <= MODE_BAUD;
        i_target   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n    <= 1'b1;
        @(posedge i_clk);

        // Reset settings, 50000 kHz / 50 MHz.
        queue_request(MODE_BAUD, '0);           // first zero rate at prescaler 2
        queue_request(MODE_BAUD, TARGET_MAX);   // far above everything: 0/0
        queue_request(MODE_BAUD, 31'd25000);    // exact on the first pair
        queue_request(MODE_BAUD, 31'd12500);    // exact, later duplicates ignored
        queue_request(MODE_BAUD, 31'd18750);    // tie between 25000 and 12500
        queue_request(MODE_BAUD, 31'd6250);     // exact, first of two equal pairs
        queue_request(MODE_BAUD, 31'd1);        // largest scaler
        queue_request(MODE_BAUD, 31'd3571);     // only prescaler 7 hits this
        queue_request(MODE_DELAY, 31'd320);     // exact on the first pair
        queue_request(MODE_DELAY, '0);
        queue_request(MODE_DELAY, TARGET_MAX);  // longest delay wins
        queue_request(MODE_DELAY, 31'd1000);
        queue_request(MODE_DELAY, 31'd960);
        drive_requests();

        // Zero bus clocks: baud candidates all zero, MHz taken as 1, so delay
        // candidates run past 2^31 and the difference must not wrap.
        write_register(CFG_BUS_KHZ, '0);
        write_register(CFG_BUS_MHZ, '0);
        queue_request(MODE_BAUD, '0);
        queue_request(MODE_BAUD, 31'd777);
        queue_request(MODE_DELAY, '0);
        queue_request(MODE_DELAY, TARGET_MAX);
        drive_requests();

        // Largest register values.
        write_register(CFG_BUS_KHZ, CFG_W'(20'hFFFFF));
        write_register(CFG_BUS_MHZ, CFG_W'(10'd1023));
        queue_request(MODE_BAUD, TARGET_MAX);
        queue_request(MODE_BAUD, 31'd524287);
        queue_request(MODE_DELAY, 31'd15);
        queue_request(MODE_DELAY, 31'd100);
        drive_requests();

        // Random phases, each under fresh bus clock settings. Every fourth
        // phase runs without idling on either side.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                write_register(CFG_BUS_KHZ, CFG_W'(1));
                write_register(CFG_BUS_MHZ, CFG_W'(1));
            end else begin
                write_register(CFG_BUS_KHZ, CFG_W'(pick_bus_khz()));
                write_register(CFG_BUS_MHZ, CFG_W'(pick_bus_mhz()));
            end
            steady = (phase % 4 == 1);
            for (n = 0; n < REQUESTS_PER_PHASE; n++)
                request_queue.push_back(make_random_request());
            drive_requests();
        end
        steady = 1'b0;

        // Let the last results come back, then watch for stray ones.
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
